// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/ntcu_pkg.sv -----
// types and constants of the numeric type cast unit
`timescale 1ns / 1ps
`default_nettype none
package ntcu_pkg;

    // type codes held in the source and target registers
    localparam logic [2:0] TYPE_INT32     = 3'd0;
    localparam logic [2:0] TYPE_INT64     = 3'd1;
    localparam logic [2:0] TYPE_TIMESTAMP = 3'd2;
    localparam logic [2:0] TYPE_DOUBLE    = 3'd3;
    localparam logic [2:0] TYPE_BOOL      = 3'd4;

    // register byte addresses
    localparam logic [2:0] ADDR_SOURCE = 3'd0;
    localparam logic [2:0] ADDR_TARGET = 3'd4;

    // internal representation of a type code
    typedef enum logic [1:0] {
        REP_I32,
        REP_I64,
        REP_F64,
        REP_BOOL
    } rep_t;

    // work carried by an item through the pipeline
    typedef enum logic [1:0] {
        OP_SIMPLE,
        OP_I2F,
        OP_F2I32,
        OP_F2I64
    } op_t;

    localparam logic [63:0] F64_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [10:0] F64_EXP_MAX = 11'h7FF;
    localparam logic [11:0] F64_BIAS    = 12'd1023;
    // exponent of a normalized 64-bit magnitude with bit 63 set
    localparam logic [10:0] I2F_EXP_TOP = 11'd1086;

    function automatic rep_t rep_of(input logic [2:0] code);
        rep_t r;
        case (code)
            TYPE_INT32:  r = REP_I32;
            TYPE_DOUBLE: r = REP_F64;
            TYPE_BOOL:   r = REP_BOOL;
            default:     r = REP_I64;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/numeric_type_cast_unit.sv -----
// top level of the numeric type cast unit
`timescale 1ns / 1ps
`default_nettype none
// Casts one 64-bit raw column value per beat between the types held in two
// registers: source_type (byte address 0) and target_type (byte address 4),
// codes 0 int32, 1 int64, 2 timestamp, 3 double, 4 boolean, 5..7 act as int64.
// Both reset to int64. Int widening sign-extends, int64 to int32 keeps the low
// half, int to double rounds to nearest even, double to int rounds half away
// from zero and gives zero for out of range, NaN or infinite values. Boolean
// results are 0 or 1, boolean to boolean copies the low byte. tlast passes
// through. Throughput is one beat per clock while the output is not stalled.
// A beat passes through the four-stage pipeline (decode and magnitude,
// normalize or align shift, round and range check, final negate), the last
// stage being the output register. Each stage holds its own valid bit, so
// bubbles collapse: while a finished result waits in the output register the
// input keeps taking beats until the three stages in front of it are full.
// Registers may only be written while no beat is in flight.
module numeric_type_cast_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] value_bits
    input  wire logic        s_tlast,   // end_of_batch
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // [63:0] result_bits
    output logic             m_tlast    // end_of_batch_out
);

    // configuration registers
    logic [2:0] src_type_reg, tgt_type_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_type_reg <= ntcu_pkg::TYPE_INT64;
            tgt_type_reg <= ntcu_pkg::TYPE_INT64;
        end else if (cfg_wr) begin
            // decode on the word select bit only
            if (paddr[2] == ntcu_pkg::ADDR_TARGET[2]) begin
                tgt_type_reg <= pwdata[2:0];
            end else begin
                src_type_reg <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ntcu_pkg::ADDR_TARGET[2]) begin
            prdata = {29'd0, tgt_type_reg};
        end else begin
            prdata = {29'd0, src_type_reg};
        end
    end

    // stage enables, bubbles collapse
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: decode, easy casts, integer magnitude
    ntcu_pkg::rep_t rf, rt;
    ntcu_pkg::op_t  op1_next;
    logic [63:0]    res1_next, val1_next, sext;
    logic           sign1_next;

    assign rf   = ntcu_pkg::rep_of(src_type_reg);
    assign rt   = ntcu_pkg::rep_of(tgt_type_reg);
    assign sext = {{32{s_tdata[31]}}, s_tdata[31:0]};

    always_comb begin
        op1_next   = ntcu_pkg::OP_SIMPLE;
        res1_next  = s_tdata;
        val1_next  = s_tdata;
        sign1_next = s_tdata[63];
        if (rf == ntcu_pkg::REP_BOOL) begin
            if (rt == ntcu_pkg::REP_BOOL) begin
                res1_next = {56'd0, s_tdata[7:0]};
            end else if (rt == ntcu_pkg::REP_F64) begin
                res1_next = (|s_tdata[7:0]) ? ntcu_pkg::F64_ONE : 64'd0;
            end else begin
                res1_next = {63'd0, |s_tdata[7:0]};
            end
        end else if (rt == ntcu_pkg::REP_BOOL) begin
            if (rf == ntcu_pkg::REP_F64) begin
                // minus zero counts as zero
                res1_next = {63'd0, |s_tdata[62:0]};
            end else if (rf == ntcu_pkg::REP_I32) begin
                res1_next = {63'd0, |s_tdata[31:0]};
            end else begin
                res1_next = {63'd0, |s_tdata};
            end
        end else if (rf == rt) begin
            res1_next = (rf == ntcu_pkg::REP_I32) ? {32'd0, s_tdata[31:0]} : s_tdata;
        end else if (rf == ntcu_pkg::REP_I32 && rt == ntcu_pkg::REP_I64) begin
            res1_next = sext;
        end else if (rf == ntcu_pkg::REP_I64 && rt == ntcu_pkg::REP_I32) begin
            res1_next = {32'd0, s_tdata[31:0]};
        end else if (rf == ntcu_pkg::REP_F64) begin
            op1_next = (rt == ntcu_pkg::REP_I32) ? ntcu_pkg::OP_F2I32 : ntcu_pkg::OP_F2I64;
        end else begin
            // integer to double: keep sign and magnitude
            op1_next   = ntcu_pkg::OP_I2F;
            sign1_next = (rf == ntcu_pkg::REP_I32) ? s_tdata[31] : s_tdata[63];
            val1_next  = (rf == ntcu_pkg::REP_I32) ? sext : s_tdata;
            if (sign1_next) val1_next = ~val1_next + 64'd1;
        end
    end

    ntcu_pkg::op_t op1_reg, op2_reg, op3_reg;
    logic [63:0]   res1_reg, val1_reg;
    logic          sign1_reg, last1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg   <= op1_next;
            res1_reg  <= res1_next;
            val1_reg  <= val1_next;
            sign1_reg <= sign1_next;
            last1_reg <= s_tlast;
        end
    end

    // ---------------- stage 2: normalize (int to double) or align (double to int)
    logic [6:0]  lz;
    logic [63:0] norm;
    logic [11:0] k;
    logic [52:0] mant;
    logic [53:0] aligned;
    logic [63:0] r2_next, val2_next;
    logic        half2_next, bad2_next, small2_next;

    always_comb begin
        lz = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (val1_reg[i]) lz = 7'(63 - i);
        end
    end

    assign norm = val1_reg << lz[5:0];
    assign k    = {1'b0, val1_reg[62:52]} - ntcu_pkg::F64_BIAS;
    assign mant = {1'b1, val1_reg[51:0]};

    always_comb begin
        aligned     = '0;
        r2_next     = '0;
        half2_next  = 1'b0;
        bad2_next   = (val1_reg[62:52] == ntcu_pkg::F64_EXP_MAX) ||
                      (!k[11] && k >= 12'd64);
        small2_next = k[11] && (k != 12'hFFF);  // below one half
        if (!k[11] && k >= 12'd52) begin
            r2_next = {11'd0, mant} << 4'(k - 12'd52);
        end else begin
            aligned    = {mant, 1'b0} >> 6'(12'd52 - k);
            r2_next    = {11'd0, aligned[53:1]};
            half2_next = aligned[0];
        end
        val2_next = (op1_reg == ntcu_pkg::OP_I2F) ? norm : r2_next;
    end

    logic [63:0] res2_reg, val2_reg;
    logic [10:0] exp2_reg;
    logic        sign2_reg, last2_reg, half2_reg, zero2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            op2_reg   <= op1_reg;
            res2_reg  <= res1_reg;
            val2_reg  <= val2_next;
            exp2_reg  <= ntcu_pkg::I2F_EXP_TOP - {4'd0, lz};
            sign2_reg <= sign1_reg;
            last2_reg <= last1_reg;
            half2_reg <= half2_next;
            // zero magnitude, or a double that rounds to zero or does not fit
            zero2_reg <= (op1_reg == ntcu_pkg::OP_I2F) ? (lz == 7'd64)
                                                       : (bad2_next || small2_next);
        end
    end

    // ---------------- stage 3: round, range check
    logic [63:0] r3;
    logic        up, fits;
    logic [63:0] res3_next;

    assign up = val2_reg[10] && ((|val2_reg[9:0]) || val2_reg[11]);
    assign r3 = val2_reg + {63'd0, half2_reg};

    always_comb begin
        if (op2_reg == ntcu_pkg::OP_F2I32) begin
            fits = (r3 < 64'h8000_0000) || (sign2_reg && r3 == 64'h8000_0000);
        end else begin
            fits = !r3[63] || (sign2_reg && r3 == 64'h8000_0000_0000_0000);
        end
        case (op2_reg)
            ntcu_pkg::OP_SIMPLE: res3_next = res2_reg;
            ntcu_pkg::OP_I2F:
                res3_next = zero2_reg ? 64'd0
                          : {sign2_reg, exp2_reg, val2_reg[62:11]} + {63'd0, up};
            default: res3_next = (fits && !zero2_reg) ? r3 : 64'd0;
        endcase
    end

    logic [63:0] res3_reg;
    logic        sign3_reg, last3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            op3_reg   <= op2_reg;
            res3_reg  <= res3_next;
            sign3_reg <= sign2_reg;
            last3_reg <= last2_reg;
        end
    end

    // ---------------- stage 4: apply sign, output register
    logic [63:0] signed_mag, res4_next;

    assign signed_mag = sign3_reg ? (~res3_reg + 64'd1) : res3_reg;

    always_comb begin
        case (op3_reg)
            ntcu_pkg::OP_F2I32: res4_next = {32'd0, signed_mag[31:0]};
            ntcu_pkg::OP_F2I64: res4_next = signed_mag;
            default:            res4_next = res3_reg;
        endcase
    end

    logic [63:0] res4_reg;
    logic        last4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            res4_reg  <= res4_next;
            last4_reg <= last3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = res4_reg;
    assign m_tlast  = last4_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/ntcu_checker.sv -----
// port checker for the numeric type cast unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ntcu_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tlast
);

    // reset empties the pipeline
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "beat after reset")
    // configuration port never waits
    `ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready low")
    // stalled result stays
    `ASSERT_CLK(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "beat dropped")
    `ASSERT_CLK(a_data_hold, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "beat changed")

endmodule

bind numeric_type_cast_unit ntcu_port_checker u_ntcu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- bench/ntcu_checker.sv -----
// checker module: predicts and compares every result beat of the cast unit
`timescale 1ns / 1ps
module ntcu_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [63:0] bits;
        logic        last;
    } cast_result_t;

    cast_result_t want_q[$];
    logic [2:0] src_code;
    logic [2:0] dst_code;

    function automatic logic [63:0] neg64(input logic [63:0] v);
        return ~v + 64'd1;
    endfunction

    // signed integer to binary64, round to nearest even
    function automatic logic [63:0] int_to_dbl(input logic [63:0] v);
        logic        sgn;
        logic [63:0] mag;
        logic [63:0] norm;
        logic [10:0] expo;
        logic [52:0] mant;
        logic        rnd;
        logic        sticky;
        int          lz;
        sgn = v[63];
        mag = sgn ? neg64(v) : v;
        if (mag == 64'd0)
            return 64'd0;
        lz = 0;
        while (!mag[63 - lz])
            lz++;
        norm = mag << lz;
        expo = ntcu_pkg::I2F_EXP_TOP - lz[10:0];
        mant = {1'b0, norm[62:11]};
        rnd = norm[10];
        sticky = |norm[9:0];
        if (rnd && (sticky || norm[11]))
            mant = mant + 53'd1;
        if (mant[52]) begin
            expo = expo + 11'd1;
            mant = 53'd0;
        end
        return {sgn, expo, mant[51:0]};
    endfunction

    // binary64 to signed integer, half away from zero, zero when out of range
    function automatic logic [63:0] dbl_to_int(input logic [63:0] v, input bit narrow);
        logic [10:0]  expo;
        logic [127:0] fix;
        logic [63:0]  whole;
        int           sh;
        expo = v[62:52];
        if (expo == ntcu_pkg::F64_EXP_MAX)
            return 64'd0;
        if (expo < 11'd1022)
            return 64'd0;
        // unbiased exponent
        sh = int'(expo) - 1023;
        if (sh > 63)
            return 64'd0;
        // fixed point with 64 fraction bits
        fix = {64'd0, 12'd1, v[51:0]} << 12;
        if (sh >= 0)
            fix = fix << sh;
        else
            fix = fix >> (-sh);
        whole = fix[127:64] + {63'd0, fix[63]};
        if (narrow) begin
            if (v[63] ? (whole > 64'h8000_0000) : (whole > 64'h7FFF_FFFF))
                return 64'd0;
        end else begin
            if (whole[63] && !(v[63] && whole == 64'h8000_0000_0000_0000))
                return 64'd0;
        end
        whole = v[63] ? neg64(whole) : whole;
        return narrow ? {32'd0, whole[31:0]} : whole;
    endfunction

    function automatic logic [63:0] cast_bits(input logic [63:0] v);
        ntcu_pkg::rep_t rs;
        ntcu_pkg::rep_t rd;
        logic [63:0] wide;
        rs = ntcu_pkg::rep_of(src_code);
        rd = ntcu_pkg::rep_of(dst_code);
        if (rs == ntcu_pkg::REP_BOOL) begin
            if (rd == ntcu_pkg::REP_BOOL)
                return {56'd0, v[7:0]};
            if (rd == ntcu_pkg::REP_F64)
                return (|v[7:0]) ? ntcu_pkg::F64_ONE : 64'd0;
            return {63'd0, |v[7:0]};
        end
        if (rd == ntcu_pkg::REP_BOOL) begin
            if (rs == ntcu_pkg::REP_F64)
                return {63'd0, |v[62:0]};
            if (rs == ntcu_pkg::REP_I32)
                return {63'd0, |v[31:0]};
            return {63'd0, |v};
        end
        if (rs == rd)
            return rs == ntcu_pkg::REP_I32 ? {32'd0, v[31:0]} : v;
        if (rs == ntcu_pkg::REP_I32) begin
            wide = {{32{v[31]}}, v[31:0]};
            return rd == ntcu_pkg::REP_I64 ? wide : int_to_dbl(wide);
        end
        if (rs == ntcu_pkg::REP_I64)
            return rd == ntcu_pkg::REP_I32 ? {32'd0, v[31:0]} : int_to_dbl(v);
        return dbl_to_int(v, rd == ntcu_pkg::REP_I32);
    endfunction

    assign pending = want_q.size();

    always @(posedge aclk) begin
        cast_result_t got;
        cast_result_t want;
        if (!aresetn) begin
            src_code <= ntcu_pkg::TYPE_INT64;
            dst_code <= ntcu_pkg::TYPE_INT64;
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == ntcu_pkg::ADDR_SOURCE)
                    src_code <= pwdata[2:0];
                else if (paddr == ntcu_pkg::ADDR_TARGET)
                    dst_code <= pwdata[2:0];
            end
            if (s_tvalid && s_tready)
                want_q.push_back('{cast_bits(s_tdata), s_tlast});
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tlast};
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h/%b", $time, m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = want_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: src %0d dst %0d expected %h/%b actual %h/%b",
                                 $time, src_code, dst_code, want.bits, want.last,
                                 got.bits, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/numeric_type_cast_unit_tb.sv -----
// testbench top: stimulus, configuration phases and verdict for the cast unit
`timescale 1ns / 1ps
module numeric_type_cast_unit_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 52;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          beats_sent;
    int          phases_run;

    always #4 aclk = ~aclk;

    numeric_type_cast_unit dut (.*);

    ntcu_checker checker_i (.*);

    // watchdog: any cycle without a beat on either side counts toward the limit
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: a random stall before each beat, or none
    initial begin
        int hold;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            repeat (hold) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk iff pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // one input beat, after a random gap; valid stays up across back-to-back beats
    task automatic send_value(input logic [63:0] v, input logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tlast <= last;
        @(posedge aclk iff s_tready);
        beats_sent++;
    endtask

    // wait until every result is back before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random value shaped for the source type: edges of doubles near integers and limits
    function automatic logic [63:0] shaped_value(input logic [2:0] src);
        logic [63:0] v;
        logic [10:0] ex;
        v = rand64();
        case ($urandom_range(0, 5))
            0: v = rand64() >> $urandom_range(0, 63);
            1: v = {64{v[0]}} ^ (64'd1 << $urandom_range(0, 63));
            2: if (src == ntcu_pkg::TYPE_BOOL) v[7:0] = 8'($urandom_range(0, 1));
            default: ;
        endcase
        if (src == ntcu_pkg::TYPE_DOUBLE && $urandom_range(0, 3) != 0) begin
            // exponents around the rounding and range boundaries
            ex = 11'd1020 + 11'($urandom_range(0, 70));
            v[62:52] = ex;
            if ($urandom_range(0, 2) == 0)
                v[51:0] = v[51:0] & ~(52'hF_FFFF_FFFF_FFFF >> $urandom_range(0, 52));
        end
        return v;
    endfunction

    task automatic run_phase(input logic [2:0] src, input logic [2:0] dst, input int count);
        reg_write(ntcu_pkg::ADDR_SOURCE, ($urandom() & 32'hFFFF_FFF8) | {29'd0, src});
        reg_write(ntcu_pkg::ADDR_TARGET, ($urandom() & 32'hFFFF_FFF8) | {29'd0, dst});
        repeat (count)
            send_value(shaped_value(src), $urandom_range(0, 7) == 0);
        drain();
        phases_run++;
    endtask

    initial begin
        logic [63:0] edge_vals[$];
        beats_sent = 0;
        phases_run = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset setting (int64 copy), then double to int32 and double to bool edge cases
        edge_vals = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                      64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000,
                      64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                      64'h4004_0000_0000_0000, 64'hC004_0000_0000_0000,
                      64'h41E0_0000_0000_0000, 64'hC1E0_0000_0000_0000,
                      64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
                      64'h3FDF_FFFF_FFFF_FFFF, 64'h41DF_FFFF_FFFF_FFFF,
                      64'h4330_0000_0000_0001};
        foreach (edge_vals[i])
            send_value(edge_vals[i], i == edge_vals.size() - 1);
        drain();
        reg_write(ntcu_pkg::ADDR_SOURCE, {29'd0, ntcu_pkg::TYPE_DOUBLE});
        reg_write(ntcu_pkg::ADDR_TARGET, {29'd0, ntcu_pkg::TYPE_INT32});
        foreach (edge_vals[i])
            send_value(edge_vals[i], i[0]);
        drain();
        reg_write(ntcu_pkg::ADDR_TARGET, {29'd0, ntcu_pkg::TYPE_BOOL});
        foreach (edge_vals[i])
            send_value(edge_vals[i], 1'b0);
        drain();

        // random: pairs of codes 0..7 where either code is 0..4 or the source is 7, so unused codes are covered too
        for (int s = 0; s < 8; s++)
            for (int d = 0; d < 8; d++)
                if (s < 5 || d < 5 || s == 7)
                    run_phase(s[2:0], d[2:0], s < 5 && d < 5 ? RANDOM_PER_PHASE : 8);
        drain();

        $display("%0d beats sent over %0d register settings, all type pairs and edge doubles",
                 beats_sent, phases_run + 3);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
